>>> sv/mudp_pkg.sv
// ----------------------------------------------------------------------------
// MoldUDP64 frame parser package
// Shared phase codes, result kinds, header offsets, queue geometry and the result word types.
// ----------------------------------------------------------------------------
`default_nettype none

package mudp_pkg;

  // Parse phases.
  localparam logic [3:0] PH_ETH   = 4'd0;
  localparam logic [3:0] PH_IP    = 4'd1;
  localparam logic [3:0] PH_UDP   = 4'd2;
  localparam logic [3:0] PH_PRE   = 4'd3;
  localparam logic [3:0] PH_LENHI = 4'd4;
  localparam logic [3:0] PH_LENLO = 4'd5;
  localparam logic [3:0] PH_MSG   = 4'd6;
  localparam logic [3:0] PH_DONE  = 4'd7;
  localparam logic [3:0] PH_SKIP  = 4'd8;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;

  // Header constants and byte offsets.
  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  IP_PROTO_UDP     = 8'd17;
  localparam logic [5:0]  IP_MIN_HDR_BYTES = 6'd20;
  localparam logic [15:0] UDP_HDR_BYTES    = 16'd8;
  localparam logic [5:0]  ETH_TYPE_HI_POS  = 6'd12;
  localparam logic [5:0]  ETH_TYPE_LO_POS  = 6'd13;
  localparam logic [5:0]  IP_PROTO_POS     = 6'd9;
  localparam logic [5:0]  UDP_LEN_HI_POS   = 6'd4;
  localparam logic [5:0]  UDP_LEN_LO_POS   = 6'd5;
  localparam logic [5:0]  UDP_HDR_LAST_POS = 6'd7;
  localparam logic [5:0]  PRE_COUNT_HI_POS = 6'd18;
  localparam logic [5:0]  PRE_COUNT_LO_POS = 6'd19;

  // Output queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  message_byte;
    logic        message_first;
    logic        message_last;
    logic [15:0] message_length;
    logic        frame_skipped;
    logic [15:0] frame_messages;
    logic        frame_error;
    logic        message_aborted;
  } result_t;

  // Which of the two result slots of one step carry a word.
  typedef struct packed {
    logic first_valid;
    logic second_valid;
  } wr_ctl_t;

endpackage

`default_nettype wire

>>> sv/mudp_parse_core.sv
// ----------------------------------------------------------------------------
// MoldUDP64 parse core
// Per-frame header and message state; one input byte per step, up to two
// result words (a message word and the frame summary) per step.
// ----------------------------------------------------------------------------
`default_nettype none

module mudp_parse_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  output mudp_pkg::result_t      res0,
  output mudp_pkg::result_t      res1,
  output mudp_pkg::wr_ctl_t      wr
);

  logic [3:0]  phase, phase_next;
  logic [5:0]  pos, pos_next;
  logic [3:0]  hdr_words, hdr_words_next;
  logic [15:0] udp_left, udp_left_next;
  logic [15:0] msgs_left, msgs_left_next;
  logic [15:0] msg_bytes_left, msg_bytes_left_next;
  logic [7:0]  len_hi, len_hi_next;
  logic [15:0] delivered, delivered_next;
  logic [15:0] msg_len, msg_len_next;

  logic [3:0]  hw_eff;
  logic [15:0] word16;
  logic        msg_emit;
  logic        done_msg;
  logic [15:0] msgs_after;
  logic        sum_skip;
  logic        sum_err;
  logic        sum_abort;
  mudp_pkg::result_t msg_res;
  mudp_pkg::result_t sum_res;

  assign word16 = {len_hi, in_byte};
  assign hw_eff = (pos == 6'd0) ? in_byte[3:0] : hdr_words;

  always_comb begin
    phase_next          = phase;
    pos_next            = pos;
    hdr_words_next      = hdr_words;
    udp_left_next       = udp_left;
    msgs_left_next      = msgs_left;
    msg_bytes_left_next = msg_bytes_left;
    len_hi_next         = len_hi;
    delivered_next      = delivered;
    msg_len_next        = msg_len;
    msg_emit            = 1'b0;
    done_msg            = 1'b0;
    msg_res             = '0;
    msgs_after          = msgs_left - 16'd1;

    case (phase)
      mudp_pkg::PH_ETH: begin
        if (pos == mudp_pkg::ETH_TYPE_HI_POS) begin
          len_hi_next = in_byte;
        end
        if (pos == mudp_pkg::ETH_TYPE_LO_POS) begin
          if (word16 != mudp_pkg::ETHERTYPE_IPV4) begin
            phase_next = mudp_pkg::PH_SKIP;
          end else begin
            phase_next = mudp_pkg::PH_IP;
            pos_next   = 6'd0;
          end
        end else begin
          pos_next = pos + 6'd1;
        end
      end
      mudp_pkg::PH_IP: begin
        if (pos == 6'd0 && {in_byte[3:0], 2'b00} < mudp_pkg::IP_MIN_HDR_BYTES) begin
          phase_next = mudp_pkg::PH_SKIP;
        end else if (pos == mudp_pkg::IP_PROTO_POS && in_byte != mudp_pkg::IP_PROTO_UDP) begin
          phase_next = mudp_pkg::PH_SKIP;
        end else begin
          hdr_words_next = hw_eff;
          if ({1'b0, pos} + 7'd1 >= {1'b0, hw_eff, 2'b00}) begin
            phase_next = mudp_pkg::PH_UDP;
            pos_next   = 6'd0;
          end else begin
            pos_next = pos + 6'd1;
          end
        end
      end
      mudp_pkg::PH_UDP: begin
        if (pos == mudp_pkg::UDP_LEN_HI_POS) begin
          len_hi_next = in_byte;
        end
        if (pos == mudp_pkg::UDP_LEN_LO_POS && word16 < mudp_pkg::UDP_HDR_BYTES) begin
          phase_next = mudp_pkg::PH_SKIP;
        end else begin
          if (pos == mudp_pkg::UDP_LEN_LO_POS) begin
            udp_left_next = word16 - mudp_pkg::UDP_HDR_BYTES;
          end
          if (pos == mudp_pkg::UDP_HDR_LAST_POS) begin
            phase_next = mudp_pkg::PH_PRE;
            pos_next   = 6'd0;
          end else begin
            pos_next = pos + 6'd1;
          end
        end
      end
      mudp_pkg::PH_PRE, mudp_pkg::PH_LENHI, mudp_pkg::PH_LENLO, mudp_pkg::PH_MSG: begin
        if (udp_left != 16'd0) begin
          udp_left_next = udp_left - 16'd1;
          if (phase == mudp_pkg::PH_PRE) begin
            if (pos == mudp_pkg::PRE_COUNT_HI_POS) begin
              len_hi_next = in_byte;
            end
            if (pos == mudp_pkg::PRE_COUNT_LO_POS) begin
              msgs_left_next = word16;
              phase_next = (word16 != 16'd0) ? mudp_pkg::PH_LENHI : mudp_pkg::PH_DONE;
            end else begin
              pos_next = pos + 6'd1;
            end
          end else if (phase == mudp_pkg::PH_LENHI) begin
            len_hi_next = in_byte;
            phase_next  = mudp_pkg::PH_LENLO;
          end else if (phase == mudp_pkg::PH_LENLO) begin
            msg_len_next = word16;
            if (word16 == 16'd0) begin
              msg_emit     = 1'b1;
              msg_res.kind = mudp_pkg::KIND_EMPTY;
              done_msg     = 1'b1;
            end else begin
              msg_bytes_left_next = word16;
              phase_next          = mudp_pkg::PH_MSG;
            end
          end else begin
            msg_emit               = 1'b1;
            msg_res.kind           = mudp_pkg::KIND_BYTE;
            msg_res.message_byte   = in_byte;
            msg_res.message_first  = (msg_bytes_left == msg_len);
            msg_res.message_last   = (msg_bytes_left == 16'd1);
            msg_res.message_length = msg_len;
            msg_bytes_left_next    = msg_bytes_left - 16'd1;
            done_msg               = (msg_bytes_left == 16'd1);
          end
        end
      end
      default: begin
      end
    endcase

    // A message has been delivered in full.
    if (done_msg) begin
      if (delivered != 16'hffff) begin
        delivered_next = delivered + 16'd1;
      end
      msgs_left_next = msgs_after;
      phase_next = (msgs_after != 16'd0) ? mudp_pkg::PH_LENHI : mudp_pkg::PH_DONE;
    end
  end

  // The summary is judged on the phase after this byte has been taken.
  always_comb begin
    sum_skip  = (phase_next <= mudp_pkg::PH_UDP) || (phase_next == mudp_pkg::PH_SKIP);
    sum_err   = (phase_next == mudp_pkg::PH_LENHI) || (phase_next == mudp_pkg::PH_LENLO) ||
                (phase_next == mudp_pkg::PH_MSG);
    sum_abort = (phase_next == mudp_pkg::PH_MSG) && (msg_bytes_left_next < msg_len_next);
    sum_res                 = '0;
    sum_res.kind            = mudp_pkg::KIND_SUMMARY;
    sum_res.frame_skipped   = sum_skip;
    sum_res.frame_messages  = sum_skip ? 16'd0 : delivered_next;
    sum_res.frame_error     = sum_err && !sum_skip;
    sum_res.message_aborted = sum_abort;
  end

  always_comb begin
    wr.first_valid  = step && (msg_emit || in_last);
    wr.second_valid = step && msg_emit && in_last;
    res0 = msg_emit ? msg_res : sum_res;
    res1 = sum_res;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && in_last)) begin
      phase          <= mudp_pkg::PH_ETH;
      pos            <= '0;
      hdr_words      <= '0;
      udp_left       <= '0;
      msgs_left      <= '0;
      msg_bytes_left <= '0;
      len_hi         <= '0;
      delivered      <= '0;
      msg_len        <= '0;
    end else if (step) begin
      phase          <= phase_next;
      pos            <= pos_next;
      hdr_words      <= hdr_words_next;
      udp_left       <= udp_left_next;
      msgs_left      <= msgs_left_next;
      msg_bytes_left <= msg_bytes_left_next;
      len_hi         <= len_hi_next;
      delivered      <= delivered_next;
      msg_len        <= msg_len_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/mudp_out_fifo.sv
// ----------------------------------------------------------------------------
// MoldUDP64 output queue
// Small result queue that takes up to two words per cycle and hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module mudp_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mudp_pkg::wr_ctl_t wr,
  input  wire mudp_pkg::result_t wr_data0,
  input  wire mudp_pkg::result_t wr_data1,
  output logic                   space_ok,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output mudp_pkg::result_t      rd_data
);

  mudp_pkg::result_t mem [mudp_pkg::FIFO_DEPTH];

  logic [mudp_pkg::FIFO_AW-1:0] wptr, wptr_next;
  logic [mudp_pkg::FIFO_AW-1:0] rptr, rptr_next;
  logic [mudp_pkg::FIFO_CW-1:0] count, count_next;
  logic [mudp_pkg::FIFO_AW-1:0] wptr_inc;
  logic [mudp_pkg::FIFO_CW-1:0] n_wr;
  logic                         rd;

  assign rd       = rd_valid && rd_ready;
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];
  // Room for the worst case of two words from one step.
  assign space_ok = (count <= mudp_pkg::FIFO_CW'(mudp_pkg::FIFO_DEPTH - 2));
  assign wptr_inc = wptr + mudp_pkg::FIFO_AW'(1);

  always_comb begin
    n_wr       = mudp_pkg::FIFO_CW'(wr.first_valid) + mudp_pkg::FIFO_CW'(wr.second_valid);
    wptr_next  = wptr + n_wr[mudp_pkg::FIFO_AW-1:0];
    rptr_next  = rd ? rptr + mudp_pkg::FIFO_AW'(1) : rptr;
    count_next = count + n_wr - mudp_pkg::FIFO_CW'(rd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr_next;
      rptr  <= rptr_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.first_valid) begin
      mem[wptr] <= wr_data0;
    end
    if (wr.second_valid) begin
      mem[wptr_inc] <= wr_data1;
    end
  end

endmodule

`default_nettype wire

>>> sv/moldudp64_frame_parser.sv
// Path: an accepted byte waits in the input register until the queue has room for its step;
//   its result word is then written into the output queue and offered from then on.
// Throughput: one frame byte per cycle; the last byte of a frame may yield two words
//   (a message word and the summary), so the input waits while the queue holds more than two.
// Reset: rst is synchronous and active high; it drops all frame state and empties
//   the queue, after which the parser expects the first byte of an Ethernet header.
// ----------------------------------------------------------------------------
// MoldUDP64 frame parser
// Ethernet / IPv4 / UDP / MoldUDP64 deframer that streams message bytes and a
// per-frame summary word.
// ----------------------------------------------------------------------------
`default_nettype none

module moldudp64_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  // Slave side: one frame byte per word.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // frame_last
  // Master side: one result per word.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [7:0] message_byte, [8] message_first,
                                           // [24:9] message_length, [25] frame_skipped,
                                           // [41:26] frame_messages, [42] frame_error,
                                           // [43] message_aborted, [47:44] zero
  output logic             m_axis_tlast,   // message_last
  output logic [1:0]       m_axis_tuser    // result_kind
);

  // Input register. A byte waits here until the queue has room for the
  // two words its step may produce.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       space_ok;
  logic       step;

  mudp_pkg::result_t res0;
  mudp_pkg::result_t res1;
  mudp_pkg::wr_ctl_t wr;
  mudp_pkg::result_t out_res;

  // The step fires from registered state only, so the slave ready never
  // depends on the master ready in the same cycle.
  assign step          = in_valid && space_ok;
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // Header walk, message framing and summary generation.
  mudp_parse_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte),
    .in_last (in_last),
    .res0    (res0),
    .res1    (res1),
    .wr      (wr)
  );

  // Result queue between the parser and the master side.
  mudp_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .wr_data0 (res0),
    .wr_data1 (res1),
    .space_ok (space_ok),
    .rd_valid (m_axis_tvalid),
    .rd_ready (m_axis_tready),
    .rd_data  (out_res)
  );

  assign m_axis_tdata = {4'b0000, out_res.message_aborted, out_res.frame_error,
                         out_res.frame_messages, out_res.frame_skipped,
                         out_res.message_length, out_res.message_first,
                         out_res.message_byte};
  assign m_axis_tlast = out_res.message_last;
  assign m_axis_tuser = out_res.kind;

  // A second word in one step only happens on a frame's last byte.
  a_two_words_on_last: assert property (@(posedge clk) disable iff (rst)
    wr.second_valid |-> (wr.first_valid && step && in_last))
    else $error("two result words from a byte that does not end a frame");

  // A second word is always the frame summary.
  a_second_is_summary: assert property (@(posedge clk) disable iff (rst)
    wr.second_valid |-> (res1.kind == mudp_pkg::KIND_SUMMARY))
    else $error("second result word is not a summary");

  // A byte held back for lack of queue room stays in the input register.
  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !space_ok) |=> (in_valid && $stable(in_byte) && $stable(in_last)))
    else $error("stalled input byte was lost or changed");

  // An accepted byte is present in the input register on the next cycle.
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> in_valid)
    else $error("accepted byte did not reach the input register");

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MoldUDP64 frame parser testbench
// Sends Ethernet frames, one byte per word, built from a table of directed
// cases and then from random frame descriptions. A software copy of the
// deframer predicts every message word and every frame summary, and each
// word that leaves the parser is compared field by field with the oldest
// prediction. The random frames run in three phases: receiver slow, sender slow, no idling.
// ----------------------------------------------------------------------------
module testbench;

  // Description of one frame. The builder lays out a proper Ethernet, IPv4,
  // UDP and MoldUDP64 frame and then spoils it as the fields ask.
  typedef struct {
    bit [15:0] ethertype;
    bit [3:0]  ihl;        // IPv4 header length in 32-bit words
    bit [7:0]  proto;
    int        nmsg;       // messages laid out in the payload
    int        count_adj;  // declared message count is nmsg plus this
    int        msg_len;    // declared length of every message, -1 for random
    int        udp_len;    // UDP length field, -1 for the true length
    int        udp_adj;    // added to the true UDP length
    int        cut;        // >0 keeps that many bytes, <0 drops bytes at the end
    int        pad;        // bytes after the datagram
    int        noise;      // >0 sends that many random bytes instead
    bit        typed;      // the summary below is known in advance
    bit        t_skip;
    int        t_msgs;
    bit        t_err;
    bit        t_abort;
  } frame_spec_t;

  // Message bodies longer than this are cut short, so that huge declared
  // lengths end up as messages cut off by the end of the payload.
  localparam int BODY_CAP = 48;
  localparam int RANDOM_BYTES_PER_PHASE = 200;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;   // frame_last
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [47:0] m_axis_tdata;          // [7:0] message_byte, [8] message_first,
                                      // [24:9] message_length, [25] frame_skipped,
                                      // [41:26] frame_messages, [42] frame_error,
                                      // [43] message_aborted, [47:44] zero
  wire         m_axis_tlast;          // message_last
  wire  [1:0]  m_axis_tuser;          // result_kind

  moldudp64_frame_parser uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Words the parser still owes us, oldest first.
  mudp_pkg::result_t words_due[$];
  logic [7:0]        frame_q[$];
  int                fail_count = 0;
  int                idle_mode = 0;  // 0: receiver slow, 1: sender slow, 2: no idling
  int                hold_left = 0;
  bit                hold_done = 1'b0;

  // --------------------------------------------------------------------------
  // Deframer state, kept apart from the parser's own.
  // --------------------------------------------------------------------------
  logic [3:0]  ph;
  logic [15:0] pos;
  logic [5:0]  ihl_words;
  logic [15:0] payload_left;
  logic [15:0] msgs_left;
  logic [15:0] body_left;
  logic [7:0]  hi_byte;
  logic [15:0] delivered;
  logic        err_flag;
  logic        skip_flag;
  logic [15:0] decl_len;

  function automatic void clear_parser();
    ph = mudp_pkg::PH_ETH;
    pos = '0;
    ihl_words = '0;
    payload_left = '0;
    msgs_left = '0;
    body_left = '0;
    hi_byte = '0;
    delivered = '0;
    err_flag = 1'b0;
    skip_flag = 1'b0;
    decl_len = '0;
  endfunction

  function automatic mudp_pkg::result_t make_summary(bit skp, logic [15:0] msgs,
                                                     bit err, bit abrt);
    mudp_pkg::result_t w;
    w = '0;
    w.kind = mudp_pkg::KIND_SUMMARY;
    w.frame_skipped = skp;
    w.frame_messages = msgs;
    w.frame_error = err;
    w.message_aborted = abrt;
    return w;
  endfunction

  // A message is complete: count it (saturating) and move to the next
  // length field, or stop reading once the declared count is used up.
  function automatic void close_message();
    if (delivered != 16'hffff) delivered = delivered + 16'd1;
    msgs_left = msgs_left - 16'd1;
    ph = (msgs_left != 0) ? mudp_pkg::PH_LENHI : mudp_pkg::PH_DONE;
  endfunction

  // Advances the deframer by one accepted byte and queues the words it yields.
  function automatic void deframe_byte(logic [7:0] b, logic last);
    mudp_pkg::result_t w;
    logic [15:0]       ulen;
    bit                skp;
    bit                abrt;
    w = '0;
    case (ph)
      mudp_pkg::PH_ETH: begin
        if (pos == mudp_pkg::ETH_TYPE_HI_POS) hi_byte = b;
        if (pos == mudp_pkg::ETH_TYPE_LO_POS) begin
          if ({hi_byte, b} != mudp_pkg::ETHERTYPE_IPV4) begin
            skip_flag = 1'b1;
            ph = mudp_pkg::PH_SKIP;
          end else begin
            ph = mudp_pkg::PH_IP;
            pos = '0;
          end
        end else begin
          pos = pos + 16'd1;
        end
      end
      mudp_pkg::PH_IP: begin
        if (pos == 0) ihl_words = {2'b00, b[3:0]};
        if ((pos == 0 && ihl_words * 4 < mudp_pkg::IP_MIN_HDR_BYTES) ||
            (pos == mudp_pkg::IP_PROTO_POS && b != mudp_pkg::IP_PROTO_UDP)) begin
          skip_flag = 1'b1;
          ph = mudp_pkg::PH_SKIP;
        end else if (pos + 1 >= ihl_words * 4) begin
          ph = mudp_pkg::PH_UDP;
          pos = '0;
        end else begin
          pos = pos + 16'd1;
        end
      end
      mudp_pkg::PH_UDP: begin
        if (pos == mudp_pkg::UDP_LEN_HI_POS) hi_byte = b;
        ulen = {hi_byte, b};
        if (pos == mudp_pkg::UDP_LEN_LO_POS && ulen < mudp_pkg::UDP_HDR_BYTES) begin
          skip_flag = 1'b1;
          ph = mudp_pkg::PH_SKIP;
        end else begin
          if (pos == mudp_pkg::UDP_LEN_LO_POS) payload_left = ulen - mudp_pkg::UDP_HDR_BYTES;
          if (pos == mudp_pkg::UDP_HDR_LAST_POS) begin
            ph = mudp_pkg::PH_PRE;
            pos = '0;
          end else begin
            pos = pos + 16'd1;
          end
        end
      end
      mudp_pkg::PH_PRE, mudp_pkg::PH_LENHI, mudp_pkg::PH_LENLO, mudp_pkg::PH_MSG: begin
        // Bytes beyond the UDP payload are trailing padding and ignored.
        if (payload_left != 0) begin
          payload_left = payload_left - 16'd1;
          case (ph)
            mudp_pkg::PH_PRE: begin
              if (pos == mudp_pkg::PRE_COUNT_HI_POS) hi_byte = b;
              if (pos == mudp_pkg::PRE_COUNT_LO_POS) begin
                msgs_left = {hi_byte, b};
                ph = (msgs_left != 0) ? mudp_pkg::PH_LENHI : mudp_pkg::PH_DONE;
              end else begin
                pos = pos + 16'd1;
              end
            end
            mudp_pkg::PH_LENHI: begin
              hi_byte = b;
              ph = mudp_pkg::PH_LENLO;
            end
            mudp_pkg::PH_LENLO: begin
              decl_len = {hi_byte, b};
              if (decl_len == 0) begin
                // An empty message still counts; it shows up as a marker word.
                w.kind = mudp_pkg::KIND_EMPTY;
                words_due.push_back(w);
                close_message();
              end else begin
                body_left = decl_len;
                ph = mudp_pkg::PH_MSG;
              end
            end
            default: begin
              w.kind = mudp_pkg::KIND_BYTE;
              w.message_byte = b;
              w.message_first = (body_left == decl_len);
              w.message_last = (body_left == 16'd1);
              w.message_length = decl_len;
              words_due.push_back(w);
              body_left = body_left - 16'd1;
              if (body_left == 0) close_message();
            end
          endcase
        end
      end
      default: ;
    endcase

    if (last) begin
      // Ending before the UDP header is complete counts as a skipped frame.
      skp = (ph <= mudp_pkg::PH_UDP) || (ph == mudp_pkg::PH_SKIP) || skip_flag;
      abrt = 1'b0;
      if (ph == mudp_pkg::PH_LENHI || ph == mudp_pkg::PH_LENLO) err_flag = 1'b1;
      if (ph == mudp_pkg::PH_MSG) begin
        err_flag = 1'b1;
        abrt = (body_left < decl_len);
      end
      if (skp) begin
        err_flag = 1'b0;
        delivered = '0;
      end
      words_due.push_back(make_summary(skp, delivered, err_flag, abrt));
      clear_parser();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Frame construction.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] body_byte();
    // Lean on the all-zeros and all-ones bytes now and then.
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void build_frame(frame_spec_t f);
    logic [7:0]  payload[$];
    logic [15:0] count;
    logic [15:0] ulen;
    int          hdr_len;
    int          len;
    frame_q.delete();
    if (f.noise > 0) begin
      repeat (f.noise) frame_q.push_back(8'($urandom));
      return;
    end
    repeat (12) frame_q.push_back(8'($urandom));
    frame_q.push_back(f.ethertype[15:8]);
    frame_q.push_back(f.ethertype[7:0]);

    hdr_len = (f.ihl < 5) ? 20 : 4 * f.ihl;
    for (int i = 0; i < hdr_len; i++) begin
      if (i == 0) frame_q.push_back({4'h4, f.ihl});
      else if (i == mudp_pkg::IP_PROTO_POS) frame_q.push_back(f.proto);
      else frame_q.push_back(8'($urandom));
    end

    // MoldUDP64 preamble: session and sequence number, then the count.
    count = 16'(f.nmsg + f.count_adj);
    repeat (18) payload.push_back(8'($urandom));
    payload.push_back(count[15:8]);
    payload.push_back(count[7:0]);
    for (int k = 0; k < f.nmsg; k++) begin
      if (f.msg_len >= 0) len = f.msg_len;
      else if ($urandom_range(15) == 0) len = int'($urandom_range(0, 65535));
      else len = int'($urandom_range(0, 8));
      payload.push_back(8'(len >> 8));
      payload.push_back(8'(len));
      repeat ((len < BODY_CAP) ? len : BODY_CAP) payload.push_back(body_byte());
    end

    ulen = (f.udp_len >= 0) ? 16'(f.udp_len) : 16'(payload.size() + 8 + f.udp_adj);
    repeat (4) frame_q.push_back(8'($urandom));
    frame_q.push_back(ulen[15:8]);
    frame_q.push_back(ulen[7:0]);
    repeat (2) frame_q.push_back(8'($urandom));
    foreach (payload[i]) frame_q.push_back(payload[i]);
    repeat (f.pad) frame_q.push_back(8'($urandom));

    if (f.cut > 0) begin
      while (frame_q.size() > f.cut) void'(frame_q.pop_back());
    end else if (f.cut < 0) begin
      repeat (-f.cut) if (frame_q.size() > 1) void'(frame_q.pop_back());
    end
  endfunction

  // Mostly proper frames with random content and the odd defect in the
  // message layer; the rest have broken headers or are plain noise.
  function automatic frame_spec_t random_spec();
    frame_spec_t f;
    int          r;
    f = '{16'h0800, 4'd5, mudp_pkg::IP_PROTO_UDP, 0, 0, -1, -1, 0, 0, 0, 0,
          1'b0, 1'b0, 0, 1'b0, 1'b0};
    r = $urandom_range(99);
    f.nmsg = $urandom_range(0, 3);
    if ($urandom_range(7) == 0) f.ihl = 4'($urandom_range(6, 15));
    if (r < 70) begin
      if ($urandom_range(9) == 0) f.count_adj = $urandom_range(1) ? 1 : -1;
      if ($urandom_range(7) == 0) f.udp_adj = -int'($urandom_range(1, 8));
      if ($urandom_range(7) == 0) f.cut = -int'($urandom_range(1, 8));
      if ($urandom_range(3) == 0) f.pad = $urandom_range(1, 6);
    end else if (r < 88) begin
      if ($urandom_range(3) == 0) f.ethertype = 16'($urandom);
      f.ihl = 4'($urandom);
      if ($urandom_range(1)) f.proto = 8'($urandom);
      if ($urandom_range(1)) f.udp_len = $urandom_range(0, 40);
      if ($urandom_range(1)) f.cut = $urandom_range(1, 70);
    end else begin
      f.noise = $urandom_range(1, 30);
    end
    return f;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side.
  // --------------------------------------------------------------------------
  function automatic int send_idle_pct();
    return (idle_mode == 0) ? 28 : (idle_mode == 1) ? 76 : 0;
  endfunction

  function automatic int recv_idle_pct();
    return (idle_mode == 0) ? 76 : (idle_mode == 1) ? 28 : 0;
  endfunction

  // Offers one byte, possibly after some idle cycles, and returns at the
  // edge where it was accepted. Each step drives tvalid exactly once.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    deframe_byte(b, last);
  endtask

  task automatic send_frame(input frame_spec_t f);
    build_frame(f);
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    // Where the summary is known up front it takes the place of the
    // predicted one, which is the newest word in the queue.
    if (f.typed)
      words_due[words_due.size() - 1] = make_summary(f.t_skip, 16'(f.t_msgs),
                                                     f.t_err, f.t_abort);
  endtask

  // The sender goes quiet until every word owed has come out.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (words_due.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Directed frames. Columns: ethertype, ihl, proto, nmsg, count_adj, msg_len,
  // udp_len, udp_adj, cut, pad, noise | typed, skipped, messages, error, aborted.
  // --------------------------------------------------------------------------
  frame_spec_t script[28];

  initial begin
    // One message of one byte.
    script[0]  = '{16'h0800, 5,  17, 1, 0, 1, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    // Several messages of random length.
    script[1]  = '{16'h0800, 5,  17, 5, 0, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    // Largest IPv4 header, options skipped over.
    script[2]  = '{16'h0800, 15, 17, 2, 0, 3, -1, 0, 0, 0, 0, 1, 0, 2, 0, 0};
    // Wrong ethertypes: IPv6, all ones, all zeros.
    script[3]  = '{16'h86dd, 5,  17, 1, 0, 2, -1, 0, 0, 0, 0, 1, 1, 0, 0, 0};
    script[4]  = '{16'hffff, 5,  17, 1, 0, 2, -1, 0, 0, 0, 0, 1, 1, 0, 0, 0};
    script[5]  = '{16'h0000, 5,  17, 1, 0, 2, -1, 0, 0, 0, 0, 1, 1, 0, 0, 0};
    // IPv4 header length below the minimum.
    script[6]  = '{16'h0800, 4,  17, 1, 0, 2, -1, 0, 0, 0, 0, 1, 1, 0, 0, 0};
    script[7]  = '{16'h0800, 0,  17, 1, 0, 2, -1, 0, 0, 0, 0, 1, 1, 0, 0, 0};
    // Not UDP.
    script[8]  = '{16'h0800, 5,   6, 1, 0, 2, -1, 0, 0, 0, 0, 1, 1, 0, 0, 0};
    script[9]  = '{16'h0800, 5, 255, 1, 0, 2, -1, 0, 0, 0, 0, 1, 1, 0, 0, 0};
    // UDP length below the header size.
    script[10] = '{16'h0800, 5,  17, 1, 0, 2,  7, 0, 0, 0, 0, 1, 1, 0, 0, 0};
    script[11] = '{16'h0800, 5,  17, 1, 0, 2,  0, 0, 0, 0, 0, 1, 1, 0, 0, 0};
    // Empty UDP payload, then a preamble cut short by the UDP length.
    script[12] = '{16'h0800, 5,  17, 1, 0, 2,  8, 0, 0, 0, 0, 1, 0, 0, 0, 0};
    script[13] = '{16'h0800, 5,  17, 1, 0, 2, 20, 0, 0, 0, 0, 1, 0, 0, 0, 0};
    // Message count of zero, with trailing bytes.
    script[14] = '{16'h0800, 5,  17, 0, 0, 2, -1, 0, 0, 5, 0, 1, 0, 0, 0, 0};
    // Empty messages only.
    script[15] = '{16'h0800, 5,  17, 3, 0, 0, -1, 0, 0, 0, 0, 1, 0, 3, 0, 0};
    // Count promises one message more than the payload holds.
    script[16] = '{16'h0800, 5,  17, 2, 1, 4, -1, 0, 0, 0, 0, 1, 0, 2, 1, 0};
    // Payload ends between the two length bytes.
    script[17] = '{16'h0800, 5,  17, 1, 0, 4, -1, -5, 0, 0, 0, 1, 0, 0, 1, 0};
    // Payload ends after the length, before any message byte.
    script[18] = '{16'h0800, 5,  17, 1, 0, 4, -1, -4, 0, 0, 0, 1, 0, 0, 1, 0};
    // Payload ends inside a message.
    script[19] = '{16'h0800, 5,  17, 1, 0, 4, -1, -2, 0, 0, 0, 1, 0, 0, 1, 1};
    // Frame ends inside the second message.
    script[20] = '{16'h0800, 5,  17, 2, 0, 3, -1, 0, -1, 0, 0, 1, 0, 1, 1, 1};
    // Largest declared length, far more than the frame carries.
    script[21] = '{16'h0800, 5,  17, 1, 0, 65535, -1, 0, 0, 0, 0, 1, 0, 0, 1, 1};
    // Largest message count.
    script[22] = '{16'h0800, 5,  17, 2, 65533, 1, -1, 0, 0, 0, 0, 1, 0, 2, 1, 0};
    // Largest UDP length; the frame ends after the last message.
    script[23] = '{16'h0800, 5,  17, 2, 0, 2, 65535, 0, 0, 0, 0, 1, 0, 2, 0, 0};
    // Bytes past the UDP payload are ignored.
    script[24] = '{16'h0800, 5,  17, 2, 0, 1, -1, 0, 0, 7, 0, 1, 0, 2, 0, 0};
    // Frames that stop in the Ethernet header, as one byte, and in the UDP
    // header.
    script[25] = '{16'h0800, 5,  17, 1, 0, 2, -1, 0,  6, 0, 0, 1, 1, 0, 0, 0};
    script[26] = '{16'h0800, 5,  17, 0, 0, 0, -1, 0,  0, 0, 1, 1, 1, 0, 0, 0};
    script[27] = '{16'h0800, 5,  17, 1, 0, 2, -1, 0, 39, 0, 0, 1, 1, 0, 0, 0};
  end

  // --------------------------------------------------------------------------
  // Receiver side: random backpressure, one long hold-off, and the checks.
  // --------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : receiver
    mudp_pkg::result_t got;
    mudp_pkg::result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.message_byte = m_axis_tdata[7:0];
        got.message_first = m_axis_tdata[8];
        got.message_last = m_axis_tlast;
        got.message_length = m_axis_tdata[24:9];
        got.frame_skipped = m_axis_tdata[25];
        got.frame_messages = m_axis_tdata[41:26];
        got.frame_error = m_axis_tdata[42];
        got.message_aborted = m_axis_tdata[43];
        if (words_due.size() == 0) begin
          fail_count++;
          $display("%0t ns: word with nothing expected, got %p", $time, got);
        end else begin
          want = words_due.pop_front();
          check_field("result_kind", 16'(want.kind), 16'(got.kind));
          check_field("message_byte", 16'(want.message_byte), 16'(got.message_byte));
          check_field("message_first", 16'(want.message_first), 16'(got.message_first));
          check_field("message_last", 16'(want.message_last), 16'(got.message_last));
          check_field("message_length", want.message_length, got.message_length);
          check_field("frame_skipped", 16'(want.frame_skipped), 16'(got.frame_skipped));
          check_field("frame_messages", want.frame_messages, got.frame_messages);
          check_field("frame_error", 16'(want.frame_error), 16'(got.frame_error));
          check_field("message_aborted", 16'(want.message_aborted),
                      16'(got.message_aborted));
        end
      end
      // When the sender turns slow the receiver first stops for a long
      // stretch, long enough for the output queue to fill and the parser
      // to push back on its input.
      if (idle_mode == 1 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    frame_spec_t f;
    int          sent;
    clear_parser();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_frame(script[i]);
    wait_for_results();

    // Random frames in each idling phase; the sender drains between them.
    for (int m = 0; m < 3; m++) begin
      idle_mode = m;
      sent = 0;
      while (sent < RANDOM_BYTES_PER_PHASE) begin
        f = random_spec();
        send_frame(f);
        sent += frame_q.size();
      end
      wait_for_results();
    end

    // A few more cycles to catch any word the parser should not produce.
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> moldudp64_frame_parser.f
sv/mudp_pkg.sv
sv/mudp_parse_core.sv
sv/mudp_out_fifo.sv
sv/moldudp64_frame_parser.sv
bench/testbench.sv
